>>> design/mbrd_pkg.sv
`default_nettype none

package mbrd_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  EXC_BIT  = 8'h80;
    localparam logic [8:0]  POS_MAX  = 9'd511;
    localparam int          MIN_LEN  = 6;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_CRC_ERR   = 3'd2,
        ST_EXCEPTION = 3'd3,
        ST_OVERRUN   = 3'd4
    } status_t;

    typedef enum logic {
        KIND_WORD   = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] word;
        logic [6:0]  word_index;
        status_t     status;
        logic [7:0]  slave_address;
        logic [7:0]  function_byte;
        logic [7:0]  data_length;
    } result_t;

    // One byte through the reflected CRC-16, eight shift steps unrolled.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                              input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0])
            begin
                crc = (crc >> 1) ^ CRC_POLY;
            end
            else
            begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

>>> design/mbrd_core.sv
`default_nettype none

module mbrd_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [7:0]       data_byte,
    input  wire logic             frame_end,
    output logic                  res_valid,
    output mbrd_pkg::result_t     res
);
    import mbrd_pkg::*;

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  held0_reg, held0_next;
    logic [7:0]  held1_reg, held1_next;
    logic [8:0]  pos_reg, pos_next;
    logic [7:0]  addr_reg, addr_next;
    logic [7:0]  func_reg, func_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  high_reg, high_next;

    logic [15:0] crc_cur;
    logic [7:0]  addr_eff, func_eff, count_eff;
    logic [9:0]  frame_len;
    logic [15:0] wire_crc;
    logic [8:0]  data_idx;
    status_t     status;
    logic        word_hit;

    always_comb
    begin
        crc_cur   = (pos_reg >= 9'd2) ? crc_byte(crc_reg, held0_reg) : crc_reg;
        addr_eff  = (pos_reg == 9'd0) ? data_byte : addr_reg;
        func_eff  = (pos_reg == 9'd1) ? data_byte : func_reg;
        count_eff = (pos_reg == 9'd2) ? data_byte : count_reg;
        frame_len = {1'b0, pos_reg} + 10'd1;
        wire_crc  = {data_byte, held1_reg};
        data_idx  = pos_reg - 9'd3;
        word_hit  = (pos_reg >= 9'd3) && data_idx[0]
                    && (data_idx[8:1] < {1'b0, count_reg[7:1]});

        // Checks are taken in priority order; the first failure wins.
        if (frame_len < 10'(MIN_LEN))
        begin
            status = ST_SHORT;
        end
        else if (crc_cur != wire_crc)
        begin
            status = ST_CRC_ERR;
        end
        else if ((func_eff & EXC_BIT) != 8'h00)
        begin
            status = ST_EXCEPTION;
        end
        else if (({2'b00, count_eff} + 10'd5) > frame_len)
        begin
            status = ST_OVERRUN;
        end
        else
        begin
            status = ST_OK;
        end
    end

    always_comb
    begin
        res.slave_address = addr_eff;
        res.function_byte = func_eff;
        res.data_length   = count_eff;
        if (frame_end)
        begin
            res_valid      = 1'b1;
            res.kind       = KIND_STATUS;
            res.word       = 16'h0000;
            res.word_index = (status == ST_OK) ? count_eff[7:1] : 7'd0;
            res.status     = status;
        end
        else
        begin
            res_valid      = word_hit;
            res.kind       = KIND_WORD;
            res.word       = {high_reg, data_byte};
            res.word_index = data_idx[7:1];
            res.status     = ST_OK;
        end
    end

    always_comb
    begin
        crc_next   = crc_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        pos_next   = pos_reg;
        addr_next  = addr_reg;
        func_next  = func_reg;
        count_next = count_reg;
        high_next  = high_reg;
        if (step)
        begin
            if (frame_end)
            begin
                crc_next   = CRC_INIT;
                held0_next = 8'h00;
                held1_next = 8'h00;
                pos_next   = 9'd0;
                addr_next  = 8'h00;
                func_next  = 8'h00;
                count_next = 8'h00;
                high_next  = 8'h00;
            end
            else
            begin
                crc_next   = crc_cur;
                held0_next = held1_reg;
                held1_next = data_byte;
                addr_next  = addr_eff;
                func_next  = func_eff;
                count_next = count_eff;
                if ((pos_reg >= 9'd3) && !data_idx[0])
                begin
                    high_next = data_byte;
                end
                if (pos_reg < POS_MAX)
                begin
                    pos_next = pos_reg + 9'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_INIT;
            held0_reg <= 8'h00;
            held1_reg <= 8'h00;
            pos_reg   <= 9'd0;
            addr_reg  <= 8'h00;
            func_reg  <= 8'h00;
            count_reg <= 8'h00;
            high_reg  <= 8'h00;
        end
        else
        begin
            crc_reg   <= crc_next;
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            pos_reg   <= pos_next;
            addr_reg  <= addr_next;
            func_reg  <= func_next;
            count_reg <= count_next;
            high_reg  <= high_next;
        end
    end

endmodule

`default_nettype wire

>>> design/modbus_rtu_response_decoder_unit.sv
// Modbus RTU response decoder.
// The slave side takes one frame byte per word in s_tdata, with s_tlast high
// on the last byte of the frame. The master side returns at most one result
// per byte: m_tuser low carries a tentative register word (valid only if the
// frame's final status turns out ok), m_tuser high carries the end-of-frame
// status together with the latched address, function code and byte count.
// A byte is captured in an input register; the decode logic (an unrolled
// eight-step CRC-16 update and the frame checks) then runs on it and its
// result is loaded into the output register once that register is empty or
// being emptied, and is offered on the master side from there.
// One byte is taken per cycle while the receiver does not stall, limited by
// the single decode pass between the two registers.
// If the receiver stalls, the output register holds its word and the input
// register still takes one more byte before s_tready drops.
// Reset empties both registers, sets the CRC to 0xFFFF and clears all frame latches,
// so the first byte after reset starts a new frame; after each status
// result the decoder returns to that same state.
`default_nettype none

module modbus_rtu_response_decoder_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [15:0] word, [22:16] word_index,
                                        // [25:23] status, [33:26] slave_address,
                                        // [41:34] function_byte,
                                        // [49:42] data_length, rest zero
    output logic             m_tuser    // [0] kind
);
    import mbrd_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg, in_byte_next;
    logic        in_last_reg, in_last_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_res_reg, out_res_next;

    logic        advance;
    logic        core_valid;
    result_t     core_res;

    // The output register can be reloaded when it is empty or being emptied.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    mbrd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (in_valid_reg && advance),
        .data_byte (in_byte_reg),
        .frame_end (in_last_reg),
        .res_valid (core_valid),
        .res       (core_res)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_byte_next   = in_byte_reg;
        in_last_next   = in_last_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (advance)
        begin
            out_valid_next = in_valid_reg && core_valid;
            out_res_next   = core_res;
            in_valid_next  = 1'b0;
        end
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
            in_byte_next  = s_tdata;
            in_last_next  = s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
        in_last_reg <= in_last_next;
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.kind;
    assign m_tdata  = {6'b000000,
                       out_res_reg.data_length,
                       out_res_reg.function_byte,
                       out_res_reg.slave_address,
                       out_res_reg.status,
                       out_res_reg.word_index,
                       out_res_reg.word};

endmodule

`default_nettype wire
